/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Configuration register file
    localparam int unsigned CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd1;

    // Register index, taken from paddr[2]
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    // Per-cycle command broadcast to every cell of the queue
    typedef struct packed {
        logic step;     // a sample word is taken this cycle
        logic shift;    // drop the front entry, move the row down by one cell
        logic restart;  // empty the queue before the sample is applied
    } swm_ctrl_t;

    // Status of the front of the queue, returned to the top level
    typedef struct packed {
        logic exp0;     // front entry leaves the window on the next sample
        logic exp1;     // second entry leaves the window as well
        logic full;     // every cell kept: no room for the sample
    } swm_stat_t;

endpackage

/* sv/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the monotonic candidate queue: value, age and valid flag.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned AGE_W        = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    // neighbor toward the back of the queue
    input  logic                           up_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] up_value,
    input  logic        [AGE_W-1:0]        up_age,
    // keep flag of the neighbor toward the front
    input  logic                           prev_keep,
    output logic                           keep,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic        [AGE_W-1:0]        age
);

    logic                           valid_reg, valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]        age_reg, age_next;

    logic                           e_valid;
    logic signed [SAMPLE_WIDTH-1:0] e_value;
    logic        [AGE_W-1:0]        e_age;
    logic                           take;

    always_comb begin
        // content seen this cycle: own slot, or the one above when shifting
        e_valid = ctrl.shift ? up_valid : valid_reg;
        e_value = ctrl.shift ? up_value : value_reg;
        e_age   = ctrl.shift ? up_age   : age_reg;
        if (ctrl.restart) begin
            e_valid = 1'b0;
        end

        // drop entries strictly smaller than the new sample
        keep = e_valid && !(e_value < sample);
        // first free slot behind the kept run takes the sample
        take = prev_keep && !keep;

        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.step) begin
            valid_next = keep || take;
            value_next = keep ? e_value : sample;
            age_next   = keep ? (e_age + AGE_W'(1)) : '0;
        end else if (ctrl.shift) begin
            valid_next = e_valid;
            value_next = e_value;
            age_next   = e_age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

/* sv/swm_chain.sv */
// ----------------------------------------------------------------------------
// swm_chain
// Row of queue cells, front at cell 0, with front status and front value.
// ----------------------------------------------------------------------------
module swm_chain #(
    parameter int unsigned WINDOW_MAX   = 64,
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned AGE_W        = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::swm_ctrl_t             ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [AGE_W-1:0]        wm1,
    output swm_pkg::swm_stat_t             stat,
    output logic signed [SAMPLE_WIDTH-1:0] front
);

    logic                           valid_w [0:WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] value_w [0:WINDOW_MAX];
    logic        [AGE_W-1:0]        age_w   [0:WINDOW_MAX];
    logic                           keep_w  [0:WINDOW_MAX];

    // empty slot beyond the last cell
    assign valid_w[WINDOW_MAX] = 1'b0;
    assign value_w[WINDOW_MAX] = '0;
    assign age_w[WINDOW_MAX]   = '0;
    // the front cell always has a kept run of length zero ahead of it
    assign keep_w[0] = 1'b1;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (AGE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sample    (sample),
            .up_valid  (valid_w[i+1]),
            .up_value  (value_w[i+1]),
            .up_age    (age_w[i+1]),
            .prev_keep (keep_w[i]),
            .keep      (keep_w[i+1]),
            .valid     (valid_w[i]),
            .value     (value_w[i]),
            .age       (age_w[i])
        );
    end

    always_comb begin
        stat.exp0 = valid_w[0] && (age_w[0] >= wm1);
        stat.exp1 = valid_w[1] && (age_w[1] >= wm1);
        stat.full = keep_w[WINDOW_MAX];
        // front after the step: surviving head, else the new sample
        front = keep_w[1] ? (ctrl.shift ? value_w[1] : value_w[0]) : sample;
    end

endmodule

/* sv/sliding_window_max.sv */
// ----------------------------------------------------------------------------
// sliding_window_max
// Running maximum over the last window_size signed samples, built as a
// monotonic candidate queue held in a row of cells.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_sample_value, s_restart
//  m_        out        m_valid / m_ready   m_window_max
//  apb       in         psel/penable/pready window_size at address 0
//
//  When more than one front entry leaves the window at once (only after the
//  window is made smaller), the word is held while the cell row shifts out
//  the expired entries one at a time, until at most one of them remains.
//  The result is registered; while it waits unaccepted, s_ready is held
//  low, and a word is taken in the same cycle that m_ready takes the result.
//  Reset empties the queue and sets window_size to 1; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_max #(
    parameter int unsigned WINDOW_MAX   = 64,
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // sample channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_value,
    input  logic                           s_restart,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_window_max,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [2:0]              paddr,
    input  logic        [31:0]             pwdata,
    output logic        [31:0]             prdata,
    output logic                           pready
);

    // age counts samples since entry; it never reaches WINDOW_MAX
    localparam int unsigned AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    // sample count saturates at the window, so it must hold WINDOW_MAX
    localparam int unsigned SEEN_W = $clog2(WINDOW_MAX + 1);
    localparam int unsigned CMP_W  = (SEEN_W > swm_pkg::CFG_W) ? SEEN_W : swm_pkg::CFG_W;

    // ---------------- configuration ----------------
    logic [swm_pkg::CFG_W-1:0] window_size_reg;
    logic                      cfg_write;
    logic                      cfg_hit;

    assign cfg_hit   = (paddr[2:2] == swm_pkg::REG_WINDOW_SIZE);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign pready    = 1'b1;
    assign prdata    = cfg_hit ? {{(32-swm_pkg::CFG_W){1'b0}}, window_size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= swm_pkg::WINDOW_SIZE_RESET;
        end else if (cfg_write) begin
            window_size_reg <= pwdata[swm_pkg::CFG_W-1:0];
        end
    end

    // Clip the window: zero acts as one, oversize acts as the full row.
    logic [CMP_W-1:0]  cfg_ext;
    logic [SEEN_W-1:0] win;
    logic [AGE_W-1:0]  wm1;

    always_comb begin
        cfg_ext = CMP_W'(window_size_reg);
        if (cfg_ext == '0) begin
            win = SEEN_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            win = SEEN_W'(WINDOW_MAX);
        end else begin
            win = SEEN_W'(cfg_ext);
        end
        wm1 = AGE_W'(win - SEEN_W'(1));
    end

    // ---------------- control ----------------
    swm_pkg::swm_ctrl_t             ctrl;
    swm_pkg::swm_stat_t             stat;
    logic signed [SAMPLE_WIDTH-1:0] front;

    logic                           m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_window_max_reg, m_window_max_next;
    logic [SEEN_W-1:0]              seen_reg, seen_next;
    logic [SEEN_W-1:0]              seen_base;

    logic multi_drop;
    logic out_free;
    logic fire;
    logic emit;

    always_comb begin
        // more than one expired front entry: drop one now, hold the word
        multi_drop = s_valid && !s_restart && stat.exp0 && stat.exp1;
        out_free   = !m_valid_reg || m_ready;
        s_ready    = !multi_drop && out_free;
        fire       = s_valid && s_ready;

        ctrl.step    = fire;
        ctrl.restart = fire && s_restart;
        ctrl.shift   = s_valid && !s_restart && stat.exp0 && (fire || multi_drop);

        // count samples of the sequence, saturating at the window
        seen_base = s_restart ? '0 : seen_reg;
        seen_next = (seen_base < win) ? (seen_base + SEEN_W'(1)) : win;
        emit      = (seen_next == win);

        m_valid_next      = m_valid_reg;
        m_window_max_next = m_window_max_reg;
        if (fire && emit) begin
            m_valid_next      = 1'b1;
            m_window_max_next = front;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            seen_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_window_max_reg <= m_window_max_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_window_max = m_window_max_reg;

    // ---------------- candidate queue ----------------
    swm_chain #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AGE_W        (AGE_W)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (s_sample_value),
        .wm1     (wm1),
        .stat    (stat),
        .front   (front)
    );

    // ---------------- assertions ----------------
    // the queue never overflows its row of cells when a sample is taken
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> !stat.full)
        else $error("candidate queue overflow");

    // a window of one returns the sample itself
    a_unit_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (win == SEEN_W'(1))) |=>
            (m_valid_reg && (m_window_max_reg == $past(s_sample_value))))
        else $error("unit window result differs from sample");

    // the maximum is never below the newest sample
    a_max_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |=> (m_window_max_reg >= $past(s_sample_value)))
        else $error("window maximum below newest sample");

endmodule
